// ----- design/blaschke_cubic_escape_iter_assert.svh -----
// Assertion helpers for the Blaschke iteration block.
`ifndef BLASCHKE_CUBIC_ESCAPE_ITER_ASSERT_SVH
`define BLASCHKE_CUBIC_ESCAPE_ITER_ASSERT_SVH

// Same-cycle implication.
`define BCE_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BCE_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bce_pkg.sv -----
package bce_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXACT,
        S_RUN
    } state_t;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIV,
        OP_SQRT,
        OP_CHK
    } op_t;

    typedef enum logic [4:0] {
        R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_T6, R_T7, R_T8,
        R_XR, R_XI, R_AR, R_AI,
        R_ONE, R_C3, R_C4, R_C16, R_ZERO
    } src_t;

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        src_t d;
    } uop_t;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_LOOP = 6'd15;
    localparam logic [PC_W-1:0] PC_LAST = 6'd48;

    localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // clamp a wide signed sum to +-QMAX
    function automatic logic signed [63:0] sat66(input logic signed [65:0] v);
        logic signed [63:0] r;
        if (v > 66'(QMAX))
            r = QMAX;
        else if (v < -66'(QMAX))
            r = -QMAX;
        else
            r = v[63:0];
        return r;
    endfunction

    // microprogram: setup of the start point, then the map loop
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = '{OP_MUL,  R_AR,  R_AR,   R_T0};
            6'd1:  u = '{OP_MUL,  R_AI,  R_AI,   R_T1};
            6'd2:  u = '{OP_ADD,  R_T0,  R_T1,   R_T0};   // n
            6'd3:  u = '{OP_ADD,  R_C3,  R_T0,   R_T1};   // b
            6'd4:  u = '{OP_MUL,  R_C16, R_T0,   R_T0};
            6'd5:  u = '{OP_MUL,  R_T1,  R_T1,   R_T2};
            6'd6:  u = '{OP_DIV,  R_T0,  R_T2,   R_T0};   // u
            6'd7:  u = '{OP_SUB,  R_ONE, R_T0,   R_T0};
            6'd8:  u = '{OP_SQRT, R_T0,  R_ZERO, R_T0};   // s
            6'd9:  u = '{OP_ADD,  R_ONE, R_T0,   R_T0};
            6'd10: u = '{OP_MUL,  R_T1,  R_T0,   R_T2};   // den
            6'd11: u = '{OP_MUL,  R_C4,  R_AR,   R_T0};
            6'd12: u = '{OP_DIV,  R_T0,  R_T2,   R_XR};
            6'd13: u = '{OP_MUL,  R_C4,  R_AI,   R_T0};
            6'd14: u = '{OP_DIV,  R_T0,  R_T2,   R_XI};
            6'd15: u = '{OP_MUL,  R_XR,  R_XR,   R_T0};
            6'd16: u = '{OP_MUL,  R_XI,  R_XI,   R_T1};
            6'd17: u = '{OP_ADD,  R_T0,  R_T1,   R_T2};   // |x|^2
            6'd18: u = '{OP_CHK,  R_T2,  R_ZERO, R_T2};
            6'd19: u = '{OP_SUB,  R_T0,  R_T1,   R_T3};   // sr
            6'd20: u = '{OP_MUL,  R_XR,  R_XI,   R_T4};
            6'd21: u = '{OP_ADD,  R_T4,  R_T4,   R_T4};   // si
            6'd22: u = '{OP_SUB,  R_XR,  R_AR,   R_T5};   // tr
            6'd23: u = '{OP_SUB,  R_XI,  R_AI,   R_T6};   // ti
            6'd24: u = '{OP_MUL,  R_T3,  R_T5,   R_T0};
            6'd25: u = '{OP_MUL,  R_T4,  R_T6,   R_T1};
            6'd26: u = '{OP_SUB,  R_T0,  R_T1,   R_T7};   // pr
            6'd27: u = '{OP_MUL,  R_T3,  R_T6,   R_T0};
            6'd28: u = '{OP_MUL,  R_T4,  R_T5,   R_T1};
            6'd29: u = '{OP_ADD,  R_T0,  R_T1,   R_T8};   // pi
            6'd30: u = '{OP_MUL,  R_AR,  R_XR,   R_T0};
            6'd31: u = '{OP_MUL,  R_AI,  R_XI,   R_T1};
            6'd32: u = '{OP_ADD,  R_T0,  R_T1,   R_T0};
            6'd33: u = '{OP_SUB,  R_ONE, R_T0,   R_T3};   // dr
            6'd34: u = '{OP_MUL,  R_AR,  R_XI,   R_T0};
            6'd35: u = '{OP_MUL,  R_AI,  R_XR,   R_T1};
            6'd36: u = '{OP_SUB,  R_T0,  R_T1,   R_T0};
            6'd37: u = '{OP_SUB,  R_ZERO, R_T0,  R_T4};   // di
            6'd38: u = '{OP_MUL,  R_T3,  R_T3,   R_T0};
            6'd39: u = '{OP_MUL,  R_T4,  R_T4,   R_T1};
            6'd40: u = '{OP_ADD,  R_T0,  R_T1,   R_T5};   // m
            6'd41: u = '{OP_MUL,  R_T7,  R_T3,   R_T0};
            6'd42: u = '{OP_MUL,  R_T8,  R_T4,   R_T1};
            6'd43: u = '{OP_ADD,  R_T0,  R_T1,   R_T6};   // nr
            6'd44: u = '{OP_MUL,  R_T8,  R_T3,   R_T0};
            6'd45: u = '{OP_MUL,  R_T7,  R_T4,   R_T1};
            6'd46: u = '{OP_SUB,  R_T0,  R_T1,   R_T0};   // ni
            6'd47: u = '{OP_DIV,  R_T6,  R_T5,   R_XR};
            6'd48: u = '{OP_DIV,  R_T0,  R_T5,   R_XI};
            default: u = '{OP_CHK, R_T2, R_ZERO, R_T2};
        endcase
        return u;
    endfunction

endpackage

// ----- design/blaschke_cubic_escape_iter.sv -----
// Channel  | Ports                                   | Handshake
// request  | start, busy, a_re, a_im                 | taken when start && !busy
// result   | done, result_code, iterations, converged| done high one cycle, no stall
// config   | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// The unit-disk test runs first; points outside return from it. Inside, setup
// of the start point takes three divides, one root and multiplies, then
// each map step takes two divides and 17 multiplies, all run in turn on the
// single shared multiply/divide/root unit.
// Reset clears the sequencer and sets max_iter to 15. The result cannot be
// stalled; busy stays high from the request until done.
`include "blaschke_cubic_escape_iter_assert.svh"

module blaschke_cubic_escape_iter
    import bce_pkg::*;
#(
    parameter int FRAC_BITS = 30
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    output logic               done,
    output logic signed [12:0] result_code,
    output logic        [7:0]  iterations,
    output logic               converged,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] C3  = ONE * 3;
    localparam logic signed [63:0] C4  = ONE <<< 2;
    localparam logic signed [63:0] C16 = ONE <<< 4;
    // 1e-6 rounded to the working format
    localparam logic signed [63:0] EPS =
        64'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam int SH_L = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
    localparam int SH_R = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
    localparam logic [63:0] DISK = 64'd1 << 60;

    // sequencer
    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg;
    logic [7:0]        cnt_reg;
    logic [7:0]        iter_reg;
    logic [7:0]        max_iter_reg;

    // working registers
    logic signed [63:0] t_reg [9];
    logic signed [63:0] xr_reg, xi_reg, ar_reg, ai_reg;
    logic signed [31:0] in_re_reg, in_im_reg;

    // shared unit
    logic [63:0]  opa_reg, opb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [66:0]  rem_reg;
    logic [63:0]  q_reg;
    logic         ovf_reg;

    logic signed [12:0] code_reg;
    logic [7:0]         iters_out_reg;
    logic               conv_reg;
    logic               done_reg;

    uop_t               uc;
    logic signed [63:0] va, vb;
    logic [31:0]        mul_x, mul_y;

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] rd(input src_t r);
        logic signed [63:0] v;
        case (r)
            R_T0:   v = t_reg[0];
            R_T1:   v = t_reg[1];
            R_T2:   v = t_reg[2];
            R_T3:   v = t_reg[3];
            R_T4:   v = t_reg[4];
            R_T5:   v = t_reg[5];
            R_T6:   v = t_reg[6];
            R_T7:   v = t_reg[7];
            R_T8:   v = t_reg[8];
            R_XR:   v = xr_reg;
            R_XI:   v = xi_reg;
            R_AR:   v = ar_reg;
            R_AI:   v = ai_reg;
            R_ONE:  v = ONE;
            R_C3:   v = C3;
            R_C4:   v = C4;
            R_C16:  v = C16;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uc = ucode(pc_reg);

    // operand read; follows register contents as well as the selects
    always_comb
    begin
        va = rd(uc.a);
        vb = rd(uc.b);
    end

    // 32x32 partial-product operand select
    always_comb
    begin
        if (state_reg == S_EXACT)
        begin
            mul_x = (cnt_reg == 8'd0) ? 32'(mag(64'(in_re_reg))) : 32'(mag(64'(in_im_reg)));
            mul_y = mul_x;
        end
        else
        begin
            mul_x = (cnt_reg == 8'd3 || cnt_reg == 8'd4) ? opa_reg[63:32] : opa_reg[31:0];
            mul_y = (cnt_reg == 8'd2 || cnt_reg == 8'd4) ? opb_reg[63:32] : opb_reg[31:0];
        end
    end

    // multiply finish: round half away, saturate
    logic [128:0]       m_rnd;
    logic               m_sat;
    logic signed [63:0] m_mag, m_res;
    assign m_rnd = {1'b0, acc_reg} + (129'd1 << (FRAC_BITS - 1));
    assign m_sat = |m_rnd[128:63+FRAC_BITS];
    assign m_mag = m_sat ? QMAX : {1'b0, m_rnd[62+FRAC_BITS:FRAC_BITS]};
    assign m_res = neg_reg ? -m_mag : m_mag;

    // add / subtract
    logic signed [63:0] as_res;
    assign as_res = (uc.op == OP_SUB) ? sat66(66'(va) - 66'(vb)) : sat66(66'(va) + 66'(vb));

    // divide step
    logic        d_cy, d_ge;
    logic [63:0] d_rem1;
    logic signed [63:0] d_mag, d_res, d_spec;
    assign d_cy   = rem_reg[63];
    assign d_rem1 = {rem_reg[62:0], acc_reg[127]};
    assign d_ge   = d_cy || (d_rem1 >= opb_reg);
    assign d_mag  = ovf_reg ? QMAX : {1'b0, q_reg[62:0]};
    assign d_res  = neg_reg ? -d_mag : d_mag;
    assign d_spec = (va > 0) ? QMAX : ((va < 0) ? -QMAX : 64'sd0);

    // root step
    logic [66:0] s_rem1, s_trial;
    logic        s_ge;
    logic signed [63:0] s_clamp;
    assign s_rem1  = {rem_reg[64:0], acc_reg[127:126]};
    assign s_trial = {1'b0, q_reg, 2'b01};
    assign s_ge    = s_rem1 >= s_trial;
    assign s_clamp = (va < 0) ? 64'sd0 : ((va > ONE) ? ONE : va);

    // step control
    logic step_last, wb_en, chk_stop, outside, fin;
    logic signed [63:0] wb_val;
    always_comb
    begin
        step_last = 1'b0;
        wb_en     = 1'b0;
        wb_val    = as_res;
        case (uc.op)
            OP_ADD, OP_SUB:
            begin
                step_last = 1'b1;
                wb_en     = 1'b1;
            end
            OP_MUL:
            begin
                step_last = cnt_reg == 8'd6;
                wb_en     = step_last;
                wb_val    = m_res;
            end
            OP_DIV:
            begin
                if (cnt_reg == 8'd0 && vb == 64'sd0)
                begin
                    step_last = 1'b1;
                    wb_val    = d_spec;
                end
                else
                begin
                    step_last = cnt_reg == 8'd129;
                    wb_val    = d_res;
                end
                wb_en = step_last;
            end
            OP_SQRT:
            begin
                step_last = cnt_reg == 8'd65;
                wb_en     = step_last;
                wb_val    = {1'b0, q_reg[62:0]};
            end
            default:
                step_last = 1'b1;
        endcase
    end

    assign chk_stop = (uc.op == OP_CHK) && ((iter_reg >= max_iter_reg) || (va <= EPS));
    assign outside  = acc_reg[63:0] > DISK;
    assign fin      = ((state_reg == S_EXACT) && (cnt_reg == 8'd3) && outside)
                   || ((state_reg == S_RUN) && chk_stop);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_EXACT;
            S_EXACT:
                if (cnt_reg == 8'd3)
                    state_next = outside ? S_IDLE : S_RUN;
            S_RUN:
                if (chk_stop)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy        = state_reg != S_IDLE;
        done        = done_reg;
        result_code = code_reg;
        iterations  = iters_out_reg;
        converged   = conv_reg;
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, max_iter_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            cnt_reg      <= '0;
            iter_reg     <= '0;
            max_iter_reg <= 8'd15;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (psel && penable && pwrite && !paddr[2])
                max_iter_reg <= pwdata[7:0];
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg  <= '0;
                    iter_reg <= '0;
                end
                S_EXACT:
                begin
                    cnt_reg <= (cnt_reg == 8'd3) ? 8'd0 : cnt_reg + 8'd1;
                    pc_reg  <= '0;
                end
                default:
                begin
                    if (step_last)
                    begin
                        cnt_reg <= '0;
                        if (pc_reg == PC_LAST)
                        begin
                            pc_reg   <= PC_LOOP;
                            iter_reg <= iter_reg + 8'd1;
                        end
                        else
                            pc_reg <= pc_reg + 6'd1;
                    end
                    else
                        cnt_reg <= cnt_reg + 8'd1;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        pp_reg <= mul_x * mul_y;
        if (state_reg == S_IDLE && start)
        begin
            in_re_reg <= a_re;
            in_im_reg <= a_im;
        end
        if (state_reg == S_EXACT)
        begin
            if (cnt_reg == 8'd1)
                acc_reg <= 128'(pp_reg);
            else if (cnt_reg == 8'd2)
                acc_reg <= acc_reg + 128'(pp_reg);
            if (FRAC_BITS >= 30)
            begin
                ar_reg <= 64'(in_re_reg) <<< SH_L;
                ai_reg <= 64'(in_im_reg) <<< SH_L;
            end
            else
            begin
                ar_reg <= 64'(in_re_reg) >>> SH_R;
                ai_reg <= 64'(in_im_reg) >>> SH_R;
            end
        end
        if (state_reg == S_RUN)
        begin
            case (uc.op)
                OP_MUL:
                begin
                    if (cnt_reg == 8'd0)
                    begin
                        opa_reg <= mag(va);
                        opb_reg <= mag(vb);
                        neg_reg <= va[63] ^ vb[63];
                        acc_reg <= '0;
                    end
                    else if (cnt_reg == 8'd2)
                        acc_reg <= acc_reg + 128'(pp_reg);
                    else if (cnt_reg == 8'd3 || cnt_reg == 8'd4)
                        acc_reg <= acc_reg + (128'(pp_reg) << 32);
                    else if (cnt_reg == 8'd5)
                        acc_reg <= acc_reg + (128'(pp_reg) << 64);
                end
                OP_DIV:
                begin
                    if (cnt_reg == 8'd0)
                    begin
                        opb_reg <= mag(vb);
                        neg_reg <= va[63] ^ vb[63];
                        acc_reg <= 128'(mag(va)) << FRAC_BITS;
                        rem_reg <= '0;
                        q_reg   <= '0;
                        ovf_reg <= 1'b0;
                    end
                    else if (cnt_reg <= 8'd128)
                    begin
                        acc_reg <= acc_reg << 1;
                        rem_reg <= {3'b000, d_ge ? d_rem1 - opb_reg : d_rem1};
                        if (cnt_reg <= 8'd65)
                        begin
                            if (d_ge)
                                ovf_reg <= 1'b1;
                        end
                        else
                            q_reg <= {q_reg[62:0], d_ge};
                    end
                end
                OP_SQRT:
                begin
                    if (cnt_reg == 8'd0)
                    begin
                        acc_reg <= 128'(s_clamp) << FRAC_BITS;
                        rem_reg <= '0;
                        q_reg   <= '0;
                    end
                    else if (cnt_reg <= 8'd64)
                    begin
                        acc_reg <= acc_reg << 2;
                        rem_reg <= s_ge ? s_rem1 - s_trial : s_rem1;
                        q_reg   <= {q_reg[62:0], s_ge};
                    end
                end
                default:
                begin
                end
            endcase
            if (wb_en)
            begin
                case (uc.d)
                    R_T0: t_reg[0] <= wb_val;
                    R_T1: t_reg[1] <= wb_val;
                    R_T2: t_reg[2] <= wb_val;
                    R_T3: t_reg[3] <= wb_val;
                    R_T4: t_reg[4] <= wb_val;
                    R_T5: t_reg[5] <= wb_val;
                    R_T6: t_reg[6] <= wb_val;
                    R_T7: t_reg[7] <= wb_val;
                    R_T8: t_reg[8] <= wb_val;
                    R_XR: xr_reg   <= wb_val;
                    R_XI: xi_reg   <= wb_val;
                    default:
                    begin
                    end
                endcase
            end
        end
        // result latch
        if (fin)
        begin
            if (state_reg == S_RUN && iter_reg < max_iter_reg)
            begin
                conv_reg      <= 1'b1;
                iters_out_reg <= iter_reg;
                code_reg      <= 13'(13'(iter_reg) * 13'd10)
                               + ((xi_reg > 0) ? 13'sd65 : 13'sd0);
            end
            else
            begin
                conv_reg      <= 1'b0;
                iters_out_reg <= (state_reg == S_RUN) ? iter_reg : 8'd0;
                code_reg      <= -13'sd1;
            end
        end
    end

    `BCE_ASSERT_IMP(a_noconv_code, clk, rst_n, done && !converged, result_code == -13'sd1,
        "non-converged result must carry code -1")
    `BCE_ASSERT_IMP(a_conv_limit, clk, rst_n, done && converged, iterations < max_iter_reg,
        "converged count must stay below the limit")
    `BCE_ASSERT_NXT(a_take_busy, clk, rst_n, start && !busy, busy,
        "block must go busy after taking a request")
    `BCE_ASSERT_IMP(a_cnt_range, clk, rst_n, state_reg != S_IDLE, cnt_reg <= 8'd129,
        "step counter ran past the longest operation")

endmodule
